>>> sv/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared command and status types between the merge sort controller and its
// datapath.
// ----------------------------------------------------------------------------
package mse_pkg;

    // which store currently holds the source runs
    localparam logic SRC_PRIMARY = 1'b0;
    localparam logic SRC_SCRATCH = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic load_we;    // write the incoming item into the primary store
        logic merge_we;   // write the merged element into the destination store
        logic src_sel;    // store that holds the source runs
        logic take_left;  // merged element comes from the left run
        logic out_load;   // load the output register from the left read port
        logic out_last;   // last flag for the loaded result
        logic out_ovf;    // overflow flag for the loaded result
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic a_lt_b;     // left head is strictly smaller than right head
        logic out_free;   // output register can take a new result
    } t_dp_sts;

endpackage

>>> sv/mse_datapath.sv
// ----------------------------------------------------------------------------
// mse_datapath
// Primary and scratch stores with registered dual read ports, merge compare,
// merge write mux and the output result register.
// ----------------------------------------------------------------------------
module mse_datapath
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS   = 64,
    parameter int VALUE_WIDTH = 32,
    localparam int AW         = $clog2(MAX_ITEMS)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic [AW-1:0]                 i_rd_addr_a,
    input  logic [AW-1:0]                 i_rd_addr_b,
    input  logic [AW-1:0]                 i_wr_addr,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  logic                          i_out_stall,
    output t_dp_sts                       o_sts,
    output logic                          o_out_valid,
    output logic signed [VALUE_WIDTH-1:0] o_value_out,
    output logic                          o_last_out,
    output logic                          o_overflow
);

    logic [VALUE_WIDTH-1:0] r_primary [MAX_ITEMS];
    logic [VALUE_WIDTH-1:0] r_scratch [MAX_ITEMS];

    logic [VALUE_WIDTH-1:0] r_pri_a;
    logic [VALUE_WIDTH-1:0] r_pri_b;
    logic [VALUE_WIDTH-1:0] r_scr_a;
    logic [VALUE_WIDTH-1:0] r_scr_b;

    logic [VALUE_WIDTH-1:0] head_a;
    logic [VALUE_WIDTH-1:0] head_b;
    logic [VALUE_WIDTH-1:0] merged;
    logic                   pri_we;
    logic                   scr_we;
    logic [VALUE_WIDTH-1:0] pri_wdata;

    logic                   r_out_valid;
    logic [VALUE_WIDTH-1:0] r_out_value;
    logic                   r_out_last;
    logic                   r_out_ovf;

    // heads of the two runs from the current source store
    assign head_a = (i_cmd.src_sel == SRC_SCRATCH) ? r_scr_a : r_pri_a;
    assign head_b = (i_cmd.src_sel == SRC_SCRATCH) ? r_scr_b : r_pri_b;
    assign merged = i_cmd.take_left ? head_a : head_b;

    // merged data goes to the store that is not the source
    assign pri_we    = i_cmd.load_we || (i_cmd.merge_we && i_cmd.src_sel == SRC_SCRATCH);
    assign scr_we    = i_cmd.merge_we && (i_cmd.src_sel == SRC_PRIMARY);
    assign pri_wdata = i_cmd.load_we ? i_value : merged;

    // primary store
    always_ff @(posedge i_clk) begin
        if (pri_we) begin
            r_primary[i_wr_addr] <= pri_wdata;
        end
        r_pri_a <= r_primary[i_rd_addr_a];
        r_pri_b <= r_primary[i_rd_addr_b];
    end

    // scratch store
    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scratch[i_wr_addr] <= merged;
        end
        r_scr_a <= r_scratch[i_rd_addr_a];
        r_scr_b <= r_scratch[i_rd_addr_b];
    end

    // output result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= head_a;
            r_out_last  <= i_cmd.out_last;
            r_out_ovf   <= i_cmd.out_ovf;
        end
    end

    // status back to the controller
    assign o_sts.a_lt_b   = $signed(head_a) < $signed(head_b);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_value_out = r_out_value;
    assign o_last_out  = r_out_last;
    assign o_overflow  = r_out_ovf;

endmodule

>>> sv/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer for loading, bottom-up merge passes and result emission. Holds
// the run pointers, run width, item count and dropped flag.
// ----------------------------------------------------------------------------
module mse_ctrl
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS = 64,
    localparam int AW       = $clog2(MAX_ITEMS),
    localparam int CW       = $clog2(MAX_ITEMS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_in,
    output logic          o_in_stall,
    input  t_dp_sts       i_sts,
    output t_dp_cmd       o_cmd,
    output logic [AW-1:0] o_rd_addr_a,
    output logic [AW-1:0] o_rd_addr_b,
    output logic [AW-1:0] o_wr_addr
);

    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_ITEMS);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] TWO_C = CW'(2);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_MERGE = 5'b00100,
        S_TURN  = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_dropped, n_dropped;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW:0]   r_width, n_width;
    logic          r_src, n_src;

    logic          in_acc;
    logic          left_ok;
    logic          right_ok;
    logic          take_left;
    logic [CW-1:0] k_inc;
    logic [SW-1:0] sum_mid;
    logic [SW-1:0] sum_hi;
    logic [SW-1:0] cnt_ext;
    logic [CW-1:0] run_mid;
    logic [CW-1:0] run_hi;
    logic [SW-1:0] dbl_w;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;

    // merge decision: left wins when strictly smaller or when the right run is exhausted
    assign left_ok   = r_i < r_mid;
    assign right_ok  = r_j < r_hi;
    assign take_left = left_ok && (!right_ok || i_sts.a_lt_b);
    assign k_inc     = r_k + ONE_C;

    // bounds of the next run pair starting at the current end
    assign cnt_ext = SW'(r_count);
    assign sum_mid = SW'(r_hi) + SW'(r_width);
    assign sum_hi  = SW'(r_hi) + (SW'(r_width) << 1);
    assign run_mid = (sum_mid > cnt_ext) ? r_count : sum_mid[CW-1:0];
    assign run_hi  = (sum_hi > cnt_ext) ? r_count : sum_hi[CW-1:0];

    // first run pair of a new pass
    assign dbl_w   = SW'(r_width) << 1;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_dropped = r_dropped;
        n_i       = r_i;
        n_j       = r_j;
        n_k       = r_k;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_width   = r_width;
        n_src     = r_src;
        o_cmd     = '0;
        o_wr_addr = r_k[AW-1:0];

        case (r_state)
            S_IDLE: begin
                o_wr_addr = r_count[AW-1:0];
                if (in_acc) begin
                    if (r_count < MAX_C) begin
                        o_cmd.load_we = 1'b1;
                        n_count       = r_count + ONE_C;
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last_in) begin
                        n_state = S_SETUP;
                    end
                end
            end

            S_SETUP: begin
                n_src = SRC_PRIMARY;
                n_i   = '0;
                n_j   = ONE_C;
                if (r_count < TWO_C) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MERGE;
                    n_mid   = ONE_C;
                    n_hi    = TWO_C;
                    n_k     = '0;
                    n_width = (CW+1)'(1);
                end
            end

            S_MERGE: begin
                o_cmd.merge_we  = 1'b1;
                o_cmd.take_left = take_left;
                n_k             = k_inc;
                if (take_left) begin
                    n_i = r_i + ONE_C;
                end else begin
                    n_j = r_j + ONE_C;
                end
                if (k_inc == r_hi) begin
                    if (r_hi == r_count) begin
                        // pass complete: swap stores, double the run width
                        n_state = S_TURN;
                        n_width = r_width << 1;
                        n_src   = ~r_src;
                        n_i     = '0;
                        n_j     = '0;
                    end else begin
                        n_i   = r_hi;
                        n_mid = run_mid;
                        n_j   = run_mid;
                        n_hi  = run_hi;
                    end
                end
            end

            S_TURN: begin
                n_i = '0;
                if (SW'(r_width) >= cnt_ext) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_MERGE;
                    n_mid   = r_width[CW-1:0];
                    n_j     = r_width[CW-1:0];
                    n_hi    = (dbl_w > cnt_ext) ? r_count : dbl_w[CW-1:0];
                    n_k     = '0;
                end
            end

            S_EMIT: begin
                if (r_i < r_count && i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = (r_i + ONE_C) == r_count;
                    o_cmd.out_ovf  = r_dropped;
                    n_i            = r_i + ONE_C;
                    if ((r_i + ONE_C) == r_count) begin
                        n_state   = S_IDLE;
                        n_count   = '0;
                        n_dropped = 1'b0;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_cmd.src_sel = r_src;
    end

    // read addresses follow the next pointers so data is ready in the following cycle
    assign o_rd_addr_a = n_i[AW-1:0];
    assign o_rd_addr_b = n_j[AW-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_src     <= SRC_PRIMARY;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_dropped <= n_dropped;
            r_src     <= n_src;
        end
    end

    // run pointers
    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_width <= n_width;
    end

endmodule

>>> sv/merge_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// merge_sort_engine_unit
// Collects a set of signed values and emits them in ascending order by a
// bottom-up merge sort between two on-chip stores.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while the block is idle; the item with
// last set closes the set, and items beyond MAX_ITEMS are dropped and flag
// overflow on every result of the run. For a set of n values the sort runs
// a setup state, then ceil(log2 n) merge passes, each followed by a
// turnaround state; the destination store takes one merged element per
// cycle through its single write port. Results then leave one per cycle
// when the output is not stalled. Input stall is high from the closing
// item until the last result has been loaded into the output register.
module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int MAX_ITEMS   = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value_in,
    input  logic                          i_last_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [VALUE_WIDTH-1:0] o_value_out,
    output logic                          o_last_out,
    output logic                          o_overflow
);

    localparam int AW = $clog2(MAX_ITEMS);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [AW-1:0] rd_addr_a;
    logic [AW-1:0] rd_addr_b;
    logic [AW-1:0] wr_addr;

    // sequencer
    mse_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_in   (i_last_in),
        .o_in_stall  (o_in_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_wr_addr   (wr_addr)
    );

    // stores, compare and output register
    mse_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .i_wr_addr   (wr_addr),
        .i_value     (i_value_in),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_value_out (o_value_out),
        .o_last_out  (o_last_out),
        .o_overflow  (o_overflow)
    );

endmodule
